// ----- sv/bm25_pkg.sv -----
// ----------------------------------------------------------------------------
// BM25 top-K package
// Shared widths, register indexes, the job type and the control enums.
// ----------------------------------------------------------------------------
package bm25_pkg;

    localparam int unsigned TopKDefault = 3;
    localparam int unsigned CfgIdxW     = 2;
    localparam int unsigned CfgDataW    = 24;

    localparam logic [CfgIdxW-1:0] CFG_AVG_LEN = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_K1      = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_B       = 2'd2;

    localparam logic [23:0] AVG_RESET = 24'd1;
    localparam logic [15:0] K1_RESET  = 16'd6144;
    localparam logic [12:0] B_RESET   = 13'd3072;

    // Term score job handed from the scorer to the ranker.
    typedef struct packed {
        logic [31:0] doc_id;
        logic [31:0] score;
        logic        query_end;
    } t_job;

    typedef enum logic [1:0] {
        S_IDLE,
        S_NORM,
        S_DIV,
        S_DONE
    } t_div_state;

    typedef enum logic [1:0] {
        R_RUN,
        R_OFFER,
        R_SORT,
        R_EMIT
    } t_rank_state;

endpackage

// ----- sv/bm25_scorer.sv -----
// ----------------------------------------------------------------------------
// BM25 term scorer
// Front part: takes a hit, computes its saturated Q16.16 term score with a
// shared radix-2 divider (length normalisation, then the main quotient).
// ----------------------------------------------------------------------------
module bm25_scorer
    import bm25_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [23:0] i_avg_len,
    input  logic [15:0] i_k1,
    input  logic [12:0] i_b,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_doc_id,
    input  logic [15:0] i_term_freq,
    input  logic [15:0] i_term_idf,
    input  logic [23:0] i_doc_length,
    input  logic        i_length_known,
    input  logic        i_query_end,
    output logic        o_valid,
    input  logic        i_ready,
    output t_job        o_job
);

    t_div_state r_state, n_state;
    logic [31:0] r_doc;
    logic        r_end;
    logic [15:0] r_tf, r_idf, r_k1;
    logic [63:0] r_num;   // dividend, shifted out
    logic [63:0] r_quo;
    logic [64:0] r_rem;
    logic [40:0] r_den;
    logic [6:0]  r_cnt;
    logic [31:0] r_score;
    logic [31:0] r_p1;
    logic        r_phase;

    logic [64:0] w_rem_sh;
    logic        w_sub;
    logic [23:0] w_avg, w_len;
    logic [12:0] w_b;
    logic [36:0] w_nnum;
    logic [40:0] w_den2;
    logic [36:0] w_n;

    assign w_avg  = (i_avg_len == '0) ? 24'd1 : i_avg_len;
    assign w_b    = (i_b > 13'd4096) ? 13'd4096 : i_b;
    assign w_len  = i_length_known ? i_doc_length : w_avg;
    assign w_nnum = 37'(13'd4096 - w_b) * 37'(w_avg) + 37'(w_b) * 37'(w_len);
    assign w_rem_sh = {r_rem[63:0], r_num[63]};
    assign w_sub  = w_rem_sh >= {24'd0, r_den};
    assign w_n    = r_quo[36:0];
    assign w_den2 = 41'({r_tf, 12'd0}) + 41'((53'(r_k1) * 53'(w_n)) >> 12);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_NORM;
            S_NORM: if (r_cnt == 7'd0) n_state = S_DIV;
            S_DIV:  if (r_cnt == 7'd0 && r_phase) n_state = S_DONE;
            S_DONE: if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == S_IDLE);
        o_valid = (r_state == S_DONE);
        o_job.doc_id    = r_doc;
        o_job.score     = r_score;
        o_job.query_end = r_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        unique case (r_state)
            S_IDLE: begin
                r_doc   <= i_doc_id;
                r_end   <= i_query_end;
                r_tf    <= i_term_freq;
                r_idf   <= i_term_idf;
                r_k1    <= i_k1;
                r_num   <= {w_nnum, 27'd0};
                r_den   <= {17'd0, w_avg};
                r_rem   <= '0;
                r_quo   <= '0;
                r_cnt   <= 7'd36;
                r_phase <= 1'b0;
            end
            S_NORM: begin
                r_num <= {r_num[62:0], 1'b0};
                r_rem <= w_sub ? w_rem_sh - {24'd0, r_den} : w_rem_sh;
                r_quo <= {r_quo[62:0], w_sub};
                if (r_cnt != 7'd0) begin
                    r_cnt <= r_cnt - 7'd1;
                end else begin
                    // Quotient n is final next cycle; set up the main division then.
                    r_cnt <= 7'd127;
                    r_p1  <= r_idf * r_tf;
                end
            end
            S_DIV: begin
                if (r_cnt == 7'd127) begin
                    r_den <= w_den2;
                    r_num <= r_p1 * ({16'd0, r_k1} + 32'd4096) * 64'd16;
                    r_rem <= '0;
                    r_quo <= '0;
                    r_cnt <= 7'd63;
                end else if (!r_phase) begin
                    r_num <= {r_num[62:0], 1'b0};
                    r_rem <= w_sub ? w_rem_sh - {24'd0, r_den} : w_rem_sh;
                    r_quo <= {r_quo[62:0], w_sub};
                    if (r_cnt != 7'd0) begin
                        r_cnt <= r_cnt - 7'd1;
                    end else begin
                        r_phase <= 1'b1;
                    end
                end else begin
                    if (r_den == '0) begin
                        r_score <= '0;
                    end else if (r_quo[63:32] != '0) begin
                        r_score <= 32'hFFFF_FFFF;
                    end else begin
                        r_score <= r_quo[31:0];
                    end
                end
            end
            S_DONE: ;
            default: ;
        endcase
    end

endmodule

// ----- sv/bm25_queue.sv -----
// ----------------------------------------------------------------------------
// BM25 job queue
// Two-entry FIFO between the scorer and the ranker.
// ----------------------------------------------------------------------------
module bm25_queue
    import bm25_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_ready,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
        if (w_push) r_mem[r_wp] <= i_job;
    end

endmodule

// ----- sv/bm25_ranker.sv -----
// ----------------------------------------------------------------------------
// BM25 ranker
// Back part: accumulates term scores per document, keeps the TOP_K best and
// at query end sorts them and streams them out best first.
// ----------------------------------------------------------------------------
module bm25_ranker
    import bm25_pkg::*;
#(
    parameter int unsigned TOP_K = TopKDefault
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_job        i_job,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_rank_position,
    output logic [31:0] o_best_doc,
    output logic [31:0] o_best_score,
    output logic        o_last_result
);

    localparam int unsigned CntW = $clog2(TOP_K + 1);
    localparam int unsigned IdxW = (TOP_K > 1) ? $clog2(TOP_K) : 1;

    t_rank_state r_state, n_state;
    logic [31:0] r_doc [TOP_K];
    logic [31:0] r_sc  [TOP_K];
    logic [CntW-1:0] r_kcnt;
    logic [31:0] r_odoc, r_osum;
    logic        r_oval, r_end2;
    logic        r_fval;
    logic [31:0] r_fdoc, r_fsum;
    logic [IdxW-1:0] r_last;
    logic [CntW-1:0] r_pass, r_emit;

    logic [32:0] w_add;
    logic        w_same;

    function automatic logic ranks_first(input logic [31:0] da, input logic [31:0] sa,
                                         input logic [31:0] db, input logic [31:0] sb);
        ranks_first = (sa != sb) ? (sa > sb) : (da < db);
    endfunction

    assign w_add  = {1'b0, r_osum} + {1'b0, i_job.score};
    assign w_same = r_oval && (i_job.doc_id == r_odoc);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            R_RUN:   if (i_valid && (!w_same || i_job.query_end)) n_state = R_OFFER;
            R_OFFER: n_state = r_end2 ? R_SORT : R_RUN;
            R_SORT:  if (r_pass == CntW'(TOP_K)) n_state = (r_kcnt == '0) ? R_RUN : R_EMIT;
            R_EMIT:  if (i_ready && r_emit + CntW'(1) == r_kcnt) n_state = R_RUN;
            default: n_state = R_RUN;
        endcase
    end

    always_comb begin
        o_ready         = (r_state == R_RUN);
        o_valid         = (r_state == R_EMIT);
        o_rank_position = 4'(r_emit);
        o_best_doc      = r_doc[r_emit[IdxW-1:0]];
        o_best_score    = r_sc[r_emit[IdxW-1:0]];
        o_last_result   = (r_emit + CntW'(1) == r_kcnt);
    end

    // Worst kept entry, found over stored lanes.
    logic [IdxW-1:0] w_last;
    always_comb begin
        w_last = '0;
        for (int i = 1; i < TOP_K; i++) begin
            if (ranks_first(r_doc[w_last], r_sc[w_last], r_doc[i], r_sc[i])) begin
                w_last = IdxW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= R_RUN;
            r_kcnt  <= '0;
            r_oval  <= 1'b0;
            r_odoc  <= '0;
            r_osum  <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                R_RUN: begin
                    if (i_valid) begin
                        r_end2 <= i_job.query_end;
                        r_last <= w_last;
                        if (w_same) begin
                            r_osum <= w_add[32] ? 32'hFFFF_FFFF : w_add[31:0];
                            r_fval <= 1'b0;
                        end else begin
                            r_fdoc <= r_odoc;
                            r_fsum <= r_osum;
                            r_odoc <= i_job.doc_id;
                            r_osum <= i_job.score;
                            r_oval <= 1'b1;
                            r_fval <= r_oval;
                        end
                    end
                end
                R_OFFER: begin
                    if (r_fval) begin
                        if (r_kcnt < CntW'(TOP_K)) begin
                            r_doc[r_kcnt[IdxW-1:0]] <= r_fdoc;
                            r_sc[r_kcnt[IdxW-1:0]]  <= r_fsum;
                            r_kcnt <= r_kcnt + CntW'(1);
                        end else if (r_fsum > r_sc[r_last]) begin
                            r_doc[r_last] <= r_fdoc;
                            r_sc[r_last]  <= r_fsum;
                        end
                    end
                    if (r_end2) begin
                        // the open document was closed by query end: offer it next
                        r_fval <= r_oval;
                        r_pass <= '0;
                    end
                end
                R_SORT: begin
                    if (r_fval && r_pass == '0) begin
                        if (r_kcnt < CntW'(TOP_K)) begin
                            r_doc[r_kcnt[IdxW-1:0]] <= r_odoc;
                            r_sc[r_kcnt[IdxW-1:0]]  <= r_osum;
                            r_kcnt <= r_kcnt + CntW'(1);
                        end else if (r_osum > r_sc[w_last]) begin
                            r_doc[w_last] <= r_odoc;
                            r_sc[w_last]  <= r_osum;
                        end
                        r_fval <= 1'b0;
                        r_oval <= 1'b0;
                        r_odoc <= '0;
                        r_osum <= '0;
                    end else begin
                        // odd-even transposition pass over the kept entries
                        for (int i = 0; i + 1 < TOP_K; i++) begin
                            if (1'(i) == r_pass[0] && CntW'(i + 1) < r_kcnt &&
                                ranks_first(r_doc[i+1], r_sc[i+1], r_doc[i], r_sc[i])) begin
                                r_doc[i]   <= r_doc[i+1];
                                r_sc[i]    <= r_sc[i+1];
                                r_doc[i+1] <= r_doc[i];
                                r_sc[i+1]  <= r_sc[i];
                            end
                        end
                        r_pass <= r_pass + CntW'(1);
                    end
                    r_emit <= '0;
                end
                R_EMIT: begin
                    if (i_ready) begin
                        r_emit <= r_emit + CntW'(1);
                        if (r_emit + CntW'(1) == r_kcnt) r_kcnt <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// ----- sv/bm25_score_top_k_select.sv -----
// ----------------------------------------------------------------------------
// BM25 score and top-K select
// Scores posting hits, sums them per document and ranks the best TOP_K.
// ----------------------------------------------------------------------------
// Usage: hits arrive on the i_valid/o_ready channel in document order; each
// carries doc id, tf, idf, length and flags. Ranked entries leave on the
// o_valid/i_ready channel best first, with rank, doc id, score and a last
// flag on the final entry; only a hit marked query_end produces output.
// Configuration registers (average length, k1, b) are written through
// i_cfg_we/i_cfg_idx/i_cfg_data; the user must write them only while the
// block is idle; the block does not enforce this. The scorer takes one hit
// at a time through the shared radix-2 divider (37 steps for length
// normalisation, 64 for the quotient); a two-entry queue lets it start the
// next hit while the ranker offers or emits. At query end the ranker offers
// and sorts, then emits one entry per cycle while the receiver takes them. A
// stalled receiver holds the current entry; the queue fills and the input
// then stalls. Reset clears all control state and restores register defaults.
// ----------------------------------------------------------------------------
module bm25_score_top_k_select
    import bm25_pkg::*;
#(
    parameter int unsigned TOP_K = TopKDefault
)(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [31:0]         i_doc_id,
    input  logic [15:0]         i_term_freq,
    input  logic [15:0]         i_term_idf,
    input  logic [23:0]         i_doc_length,
    input  logic                i_length_known,
    input  logic                i_query_end,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [3:0]          o_rank_position,
    output logic [31:0]         o_best_doc,
    output logic [31:0]         o_best_score,
    output logic                o_last_result
);

    logic [23:0] r_avg;
    logic [15:0] r_k1;
    logic [12:0] r_b;
    t_job s_job, q_job;
    logic s_valid, s_ready, q_valid, q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg <= AVG_RESET;
            r_k1  <= K1_RESET;
            r_b   <= B_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_AVG_LEN: r_avg <= i_cfg_data;
                CFG_K1:      r_k1  <= i_cfg_data[15:0];
                CFG_B:       r_b   <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    bm25_scorer u_scorer (
        .i_clk, .i_rst_n,
        .i_avg_len(r_avg), .i_k1(r_k1), .i_b(r_b),
        .i_valid, .o_ready,
        .i_doc_id, .i_term_freq, .i_term_idf, .i_doc_length,
        .i_length_known, .i_query_end,
        .o_valid(s_valid), .i_ready(s_ready), .o_job(s_job)
    );

    bm25_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(s_valid), .o_ready(s_ready), .i_job(s_job),
        .o_valid(q_valid), .i_ready(q_ready), .o_job(q_job)
    );

    bm25_ranker #(.TOP_K(TOP_K)) u_ranker (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_ready(q_ready), .i_job(q_job),
        .o_valid, .i_ready,
        .o_rank_position, .o_best_doc, .o_best_score, .o_last_result
    );

endmodule
